// ===== rtl/lfpd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PD steering: shared package
// Types, constants, the sensor error table and the sequencer control program.
// ----------------------------------------------------------------------------
package lfpd_pkg;

    // Field widths that are fixed by the interface.
    localparam int PATTERN_W = 5;
    localparam int TIME_W    = 32;
    localparam int LEVEL_W   = 8;
    localparam int GAIN_W    = 8;
    localparam int PERIOD_W  = 16;
    localparam int ERR_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // Reset values of the configuration registers and motor levels.
    localparam logic [GAIN_W-1:0]   PROP_GAIN_RST   = 8'd70;
    localparam logic [GAIN_W-1:0]   DERIV_GAIN_RST  = 8'd70;
    localparam logic [LEVEL_W-1:0]  FWD_SPEED_RST   = 8'd200;
    localparam logic [LEVEL_W-1:0]  CEILING_RST     = 8'd220;
    localparam logic [PERIOD_W-1:0] PERIOD_RST      = 16'd100;
    localparam logic [LEVEL_W-1:0]  LEVEL_RST       = 8'd150;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN     = 3'd0,
        CFG_DERIV_GAIN    = 3'd1,
        CFG_FORWARD_SPEED = 3'd2,
        CFG_SPEED_CEILING = 3'd3,
        CFG_DERIV_PERIOD  = 3'd4
    } t_cfg_idx;

    // Datapath operation selected by one control word.
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ACCEPT,
        OP_LOOKUP,
        OP_DIV_INIT,
        OP_DIV_STEP,
        OP_DIV_END,
        OP_MUL_D,
        OP_MUL_P,
        OP_STEER
    } t_op;

    // Jump condition; when it holds the step counter loads the target,
    // otherwise it advances by one.
    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_NOT_EXPIRED,
        COND_COUNT_NZ,
        COND_OUT_BUSY
    } t_cond;

    typedef logic [3:0] t_step;

    typedef struct packed {
        t_op   op;
        t_cond cond;
        t_step target;
    } t_ctrl;

    // Program step addresses.
    localparam t_step STEP_IDLE     = 4'd0;
    localparam t_step STEP_LOOKUP   = 4'd1;
    localparam t_step STEP_CHECK    = 4'd2;
    localparam t_step STEP_DIV_INIT = 4'd3;
    localparam t_step STEP_DIV_STEP = 4'd4;
    localparam t_step STEP_DIV_END  = 4'd5;
    localparam t_step STEP_MUL_D    = 4'd6;
    localparam t_step STEP_MUL_P    = 4'd7;
    localparam t_step STEP_STEER    = 4'd8;
    localparam t_step STEP_RETURN   = 4'd9;

    // Control store: one word per program step.
    function automatic t_ctrl ctrl_rom(input t_step step);
        t_ctrl w;
        unique case (step)
            STEP_IDLE:     w = '{OP_ACCEPT,   COND_NO_INPUT,    STEP_IDLE};
            STEP_LOOKUP:   w = '{OP_LOOKUP,   COND_NEXT,        STEP_IDLE};
            STEP_CHECK:    w = '{OP_NOP,      COND_NOT_EXPIRED, STEP_MUL_D};
            STEP_DIV_INIT: w = '{OP_DIV_INIT, COND_NEXT,        STEP_IDLE};
            STEP_DIV_STEP: w = '{OP_DIV_STEP, COND_COUNT_NZ,    STEP_DIV_STEP};
            STEP_DIV_END:  w = '{OP_DIV_END,  COND_NEXT,        STEP_IDLE};
            STEP_MUL_D:    w = '{OP_MUL_D,    COND_NEXT,        STEP_IDLE};
            STEP_MUL_P:    w = '{OP_MUL_P,    COND_NEXT,        STEP_IDLE};
            STEP_STEER:    w = '{OP_STEER,    COND_OUT_BUSY,    STEP_STEER};
            STEP_RETURN:   w = '{OP_NOP,      COND_ALWAYS,      STEP_IDLE};
            default:       w = '{OP_NOP,      COND_ALWAYS,      STEP_IDLE};
        endcase
        return w;
    endfunction

    // Position error of one sensor pattern, in half-units.
    typedef struct packed {
        logic                    valid;
        logic signed [ERR_W-1:0] err;
    } t_err_entry;

    function automatic t_err_entry err_lookup(input logic [PATTERN_W-1:0] pattern);
        t_err_entry e;
        case (pattern)
            5'd1:    e = '{1'b1,  4'sd4};
            5'd2:    e = '{1'b1,  4'sd2};
            5'd3:    e = '{1'b1,  4'sd3};
            5'd4:    e = '{1'b1,  4'sd0};
            5'd6:    e = '{1'b1,  4'sd1};
            5'd8:    e = '{1'b1, -4'sd2};
            5'd12:   e = '{1'b1, -4'sd1};
            5'd16:   e = '{1'b1, -4'sd4};
            5'd24:   e = '{1'b1, -4'sd3};
            default: e = '{1'b0,  4'sd0};
        endcase
        return e;
    endfunction

endpackage

// ===== rtl/line_follower_pd_steering.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Line follower PD steering controller
// Microcoded sequencer: maps a sensor pattern to a position error, divides the
// error change by elapsed time with a restoring divider, and steers two motor
// levels with a PD term clamped to the speed ceiling (forward speed if steady).
// ----------------------------------------------------------------------------
// Sequence: an accepted sample passes the lookup, check, multiply and steer
//   steps, with the divider steps after check when a derivative update is due.
// Input: a new sample is taken only in idle, after steer has loaded the last
//   result; the bit-serial divider yields one quotient bit a cycle.
// Reset: synchronous active low; restores the register defaults, clears the
//   error state and sets both motor levels to 150.
module line_follower_pd_steering #(
    parameter int DERIV_FRACTION_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Sample input channel.
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [lfpd_pkg::PATTERN_W-1:0]     i_sensor_pattern,
    input  logic [lfpd_pkg::TIME_W-1:0]        i_time_ms,
    // Result output channel.
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [lfpd_pkg::LEVEL_W-1:0]       o_right_speed,
    output logic [lfpd_pkg::LEVEL_W-1:0]       o_left_speed,
    output logic                               o_pattern_valid,
    // Configuration write channel.
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lfpd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [lfpd_pkg::CFG_DAT_W-1:0]     i_cfg_data
);
    import lfpd_pkg::*;

    localparam int F      = DERIV_FRACTION_BITS;
    localparam int DW     = F + ERR_W;          // divider dividend / quotient width
    localparam int DERW   = DW + 1;             // signed derivative width
    localparam int PW     = DERW + GAIN_W + 1;  // product and accumulator width
    localparam int DELTAW = PW - F - 1;         // steering delta width
    localparam int SUMW   = DELTAW + 1;         // level plus delta width
    localparam int CNTW   = $clog2(DW);
    localparam int PTW    = GAIN_W + 1 + ERR_W; // proportional product width

    // Configuration registers.
    logic [GAIN_W-1:0]   r_prop_gain;
    logic [GAIN_W-1:0]   r_deriv_gain;
    logic [LEVEL_W-1:0]  r_forward_speed;
    logic [LEVEL_W-1:0]  r_speed_ceiling;
    logic [PERIOD_W-1:0] r_deriv_period;

    // Controller state.
    logic [TIME_W-1:0]        r_last_stamp;
    logic signed [ERR_W-1:0]  r_prop_error;
    logic signed [ERR_W-1:0]  r_prev_error;
    logic signed [DERW-1:0]   r_deriv_error;
    logic [LEVEL_W-1:0]       r_right_level;
    logic [LEVEL_W-1:0]       r_left_level;

    // Sequencer and datapath registers.
    t_step                    r_pc;
    t_step                    n_pc;
    logic [PATTERN_W-1:0]     r_pattern;
    logic [TIME_W-1:0]        r_time;
    logic [TIME_W-1:0]        r_elapsed;
    logic                     r_pat_valid;
    logic [TIME_W-1:0]        r_rem;
    logic [DW-1:0]            r_dvd;
    logic [DW-1:0]            r_quo;
    logic                     r_neg;
    logic [CNTW-1:0]          r_cnt;
    logic signed [PW-1:0]     r_prod;
    logic signed [PW-1:0]     r_acc;
    logic                     r_out_valid;
    logic                     r_out_pat_valid;

    t_ctrl                    w_ctrl;
    t_err_entry               w_entry;
    logic                     w_cond;
    logic                     w_out_busy;
    logic                     w_expired;
    logic signed [ERR_W:0]    w_diff;
    logic [ERR_W:0]           w_mag;
    logic [TIME_W:0]          w_trial;
    logic [TIME_W:0]          w_trial_sub;
    logic                     w_ge;
    logic [DERW-1:0]          w_quo_ext;
    logic signed [PW-1:0]     w_prod_d;
    logic signed [PTW-1:0]    w_prop_term;
    logic signed [PW-1:0]     w_prop_ext;
    logic signed [DELTAW-1:0] w_delta;
    logic signed [SUMW-1:0]   w_right_sum;
    logic signed [SUMW-1:0]   w_left_sum;
    logic [LEVEL_W-1:0]       w_right_clamp;
    logic [LEVEL_W-1:0]       w_left_clamp;
    logic                     w_steady;

    // Clamp a signed level sum to the range 0 to the speed ceiling.
    function automatic logic [LEVEL_W-1:0] clamp_level(
        input logic signed [SUMW-1:0] v,
        input logic [LEVEL_W-1:0]     ceiling
    );
        logic [LEVEL_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({{(SUMW-LEVEL_W){1'b0}}, ceiling})) begin
            res = ceiling;
        end else begin
            res = v[LEVEL_W-1:0];
        end
        return res;
    endfunction

    // Control word fetch and handshake status.
    assign w_ctrl     = ctrl_rom(r_pc);
    assign o_in_stall = (r_pc != STEP_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_out_busy = r_out_valid && i_out_stall;
    assign w_expired  = r_elapsed > {{(TIME_W-PERIOD_W){1'b0}}, r_deriv_period};

    // Jump condition and next step.
    always_comb begin
        unique case (w_ctrl.cond)
            COND_NEXT:        w_cond = 1'b0;
            COND_ALWAYS:      w_cond = 1'b1;
            COND_NO_INPUT:    w_cond = !i_in_valid;
            COND_NOT_EXPIRED: w_cond = !w_expired;
            COND_COUNT_NZ:    w_cond = (r_cnt != '0);
            COND_OUT_BUSY:    w_cond = w_out_busy;
            default:          w_cond = 1'b1;
        endcase
        n_pc = w_cond ? w_ctrl.target : t_step'(r_pc + 4'd1);
    end

    // Pattern lookup and divider operand preparation.
    assign w_entry = err_lookup(r_pattern);
    assign w_diff  = {r_prop_error[ERR_W-1], r_prop_error}
                   - {r_prev_error[ERR_W-1], r_prev_error};
    assign w_mag   = w_diff[ERR_W] ? -w_diff : w_diff;

    // One restoring division step.
    assign w_trial     = {r_rem, r_dvd[DW-1]};
    assign w_trial_sub = w_trial - {1'b0, r_elapsed};
    assign w_ge        = (w_trial >= {1'b0, r_elapsed});
    assign w_quo_ext   = {1'b0, r_quo};

    // Gain products.
    assign w_prod_d    = PW'($signed({1'b0, r_deriv_gain})) * PW'(r_deriv_error);
    assign w_prop_term = PTW'($signed({1'b0, r_prop_gain})) * PTW'(r_prop_error);
    assign w_prop_ext  = PW'(w_prop_term);

    // Steering delta is a floor division by 2^(F+1).
    assign w_delta       = $signed(r_acc[PW-1:F+1]);
    assign w_right_sum   = $signed({{(SUMW-LEVEL_W){1'b0}}, r_right_level})
                         + SUMW'(w_delta);
    assign w_left_sum    = $signed({{(SUMW-LEVEL_W){1'b0}}, r_left_level})
                         - SUMW'(w_delta);
    assign w_right_clamp = clamp_level(w_right_sum, r_speed_ceiling);
    assign w_left_clamp  = clamp_level(w_left_sum, r_speed_ceiling);
    assign w_steady      = (r_prop_error == '0) && (r_deriv_error == '0);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain     <= PROP_GAIN_RST;
            r_deriv_gain    <= DERIV_GAIN_RST;
            r_forward_speed <= FWD_SPEED_RST;
            r_speed_ceiling <= CEILING_RST;
            r_deriv_period  <= PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:     r_prop_gain     <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:    r_deriv_gain    <= i_cfg_data[GAIN_W-1:0];
                CFG_FORWARD_SPEED: r_forward_speed <= i_cfg_data[LEVEL_W-1:0];
                CFG_SPEED_CEILING: r_speed_ceiling <= i_cfg_data[LEVEL_W-1:0];
                CFG_DERIV_PERIOD:  r_deriv_period  <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer, controller state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc            <= STEP_IDLE;
            r_last_stamp    <= '0;
            r_prop_error    <= '0;
            r_prev_error    <= '0;
            r_deriv_error   <= '0;
            r_right_level   <= LEVEL_RST;
            r_left_level    <= LEVEL_RST;
            r_out_valid     <= 1'b0;
        end else begin
            r_pc <= n_pc;

            // A result transaction frees the output register; the steer step
            // refills it in the same cycle on its own.
            if (r_out_valid && !i_out_stall && (w_ctrl.op != OP_STEER)) begin
                r_out_valid <= 1'b0;
            end

            unique case (w_ctrl.op)
                OP_NOP: ;
                OP_ACCEPT: begin
                    if (i_in_valid) begin
                        r_pattern <= i_sensor_pattern;
                        r_time    <= i_time_ms;
                    end
                end
                OP_LOOKUP: begin
                    if (w_entry.valid) begin
                        r_prop_error <= w_entry.err;
                    end
                    r_pat_valid <= w_entry.valid;
                    r_elapsed   <= r_time - r_last_stamp;
                end
                OP_DIV_INIT: begin
                    r_rem        <= '0;
                    r_dvd        <= {w_mag[ERR_W-1:0], {F{1'b0}}};
                    r_quo        <= '0;
                    r_neg        <= w_diff[ERR_W];
                    r_cnt        <= CNTW'(DW - 1);
                    r_last_stamp <= r_time;
                    r_prev_error <= r_prop_error;
                end
                OP_DIV_STEP: begin
                    r_rem <= w_ge ? w_trial_sub[TIME_W-1:0] : w_trial[TIME_W-1:0];
                    r_dvd <= {r_dvd[DW-2:0], 1'b0};
                    r_quo <= {r_quo[DW-2:0], w_ge};
                    r_cnt <= r_cnt - 1'b1;
                end
                OP_DIV_END: begin
                    r_deriv_error <= r_neg ? -$signed(w_quo_ext) : $signed(w_quo_ext);
                end
                OP_MUL_D: begin
                    r_prod <= w_prod_d;
                end
                OP_MUL_P: begin
                    r_acc <= r_prod + (w_prop_ext <<< F);
                end
                OP_STEER: begin
                    if (!w_out_busy) begin
                        if (w_steady) begin
                            r_right_level <= r_forward_speed;
                            r_left_level  <= r_forward_speed;
                        end else begin
                            r_right_level <= w_right_clamp;
                            r_left_level  <= w_left_clamp;
                        end
                        r_out_pat_valid <= r_pat_valid;
                        r_out_valid     <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // The motor levels double as the result payload.
    assign o_out_valid     = r_out_valid;
    assign o_right_speed   = r_right_level;
    assign o_left_speed    = r_left_level;
    assign o_pattern_valid = r_out_pat_valid;

endmodule
